// ----- src/tdas_pkg.sv -----
package tdas_pkg;

  // Field widths of one item
  localparam int OP_W    = 3;
  localparam int SYM_W   = 8;
  localparam int STATE_W = 6;
  localparam int CONC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int NUMST_W = 7;

  // Width of the effective state limit, wide enough for the largest MAX_STATES
  localparam int LIM_W = 9;

  // Bits in one transition's symbol set
  localparam int SET_BITS = 1 << SYM_W;

  // Largest conclusion store that a state field can address
  localparam int STATE_SPAN = 1 << STATE_W;

  // Parameter defaults
  localparam int DEF_MAX_STATES      = 64;
  localparam int DEF_MAX_TRANSITIONS = 32;

  // Reset value of the num_states register
  localparam logic [NUMST_W-1:0] NUM_STATES_RESET = 7'd64;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PROCESS   = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND    = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD_SYM   = 3'd2;
  localparam logic [OP_W-1:0] OP_CONFIGURE = 3'd3;
  localparam logic [OP_W-1:0] OP_RESTART   = 3'd4;

  // Verdict codes
  localparam logic [CONC_W-1:0] VERDICT_ACCEPT   = 2'd0;
  localparam logic [CONC_W-1:0] VERDICT_CONTINUE = 2'd1;
  localparam logic [CONC_W-1:0] VERDICT_REJECT   = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_RANGE     = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_NO_EXTEND = 2'd3;

  // Search token that walks down the row of transition cells
  typedef struct packed {
    logic               valid;
    logic               hit;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] state;
    logic [STATE_W-1:0] target;
  } token_t;

  // Load command broadcast to every cell
  typedef struct packed {
    logic               append;
    logic               add;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [SYM_W-1:0]   symbol;
  } load_t;

endpackage

// ----- src/table_driven_automaton_stepper_unit.sv -----
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------------
// in       | in_valid / in_ready    | operation, symbol, from_state, to_state,
//          |                        | state_index, conclusion
// out      | out_valid / out_ready  | verdict, current_state, status
// cfg      | cfg_valid / cfg_ready  | cfg_data (num_states)
//
// A load item passes through S_HOLD to the output register; a process item waits in S_SCAN
// while its search token moves one transition cell per cycle down the row, then passes
// through S_CONC when the target's conclusion is read, then S_HOLD. in_ready rises as the
// result is registered; it is low while an item is in work or its result waits for a
// full output register. Reset is synchronous: it empties the transition list, returns to
// state 0 and makes every conclusion accept; cfg_ready is always high.
module table_driven_automaton_stepper_unit #(
  parameter int MAX_STATES      = tdas_pkg::DEF_MAX_STATES,
  parameter int MAX_TRANSITIONS = tdas_pkg::DEF_MAX_TRANSITIONS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tdas_pkg::OP_W-1:0]     operation,
  input  logic [tdas_pkg::SYM_W-1:0]    symbol,
  input  logic [tdas_pkg::STATE_W-1:0]  from_state,
  input  logic [tdas_pkg::STATE_W-1:0]  to_state,
  input  logic [tdas_pkg::STATE_W-1:0]  state_index,
  input  logic [tdas_pkg::CONC_W-1:0]   conclusion,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tdas_pkg::CONC_W-1:0]   verdict,
  output logic [tdas_pkg::STATE_W-1:0]  current_state,
  output logic [tdas_pkg::STAT_W-1:0]   status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tdas_pkg::NUMST_W-1:0]  cfg_data
);

  localparam int CW         = $clog2(MAX_TRANSITIONS + 1);
  localparam int CONC_DEPTH = (MAX_STATES < tdas_pkg::STATE_SPAN) ? MAX_STATES
                                                                  : tdas_pkg::STATE_SPAN;
  localparam int CIW        = $clog2(CONC_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_CONC = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]                          state;
  logic [tdas_pkg::NUMST_W-1:0]        num_states;
  logic [tdas_pkg::LIM_W-1:0]          limit;
  logic [CW-1:0]                       count;
  logic [tdas_pkg::STATE_W-1:0]        present_state;
  logic [tdas_pkg::CONC_W-1:0]         res_verdict;
  logic [tdas_pkg::STAT_W-1:0]         res_status;
  logic                                accept;
  logic                                out_free;
  tdas_pkg::token_t                    launch;
  tdas_pkg::token_t                    tok [MAX_TRANSITIONS+1];
  tdas_pkg::token_t                    tok_end;
  tdas_pkg::load_t                     load;
  logic                                idx_in_range;
  logic                                target_in_range;
  logic [tdas_pkg::CONC_W-1:0]         conc_sat;
  logic [tdas_pkg::CONC_W-1:0]         conc_mem [CONC_DEPTH];
  logic [CONC_DEPTH-1:0]               conc_ok;
  logic [tdas_pkg::CONC_W-1:0]         conc_rd;
  logic                                conc_rd_ok;
  logic                                conc_we;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // Effective state limit is the smaller of num_states and MAX_STATES.
  assign limit = (tdas_pkg::LIM_W'(num_states) < tdas_pkg::LIM_W'(MAX_STATES))
                 ? tdas_pkg::LIM_W'(num_states) : tdas_pkg::LIM_W'(MAX_STATES);
  assign idx_in_range    = (tdas_pkg::LIM_W'(state_index) < limit);
  assign target_in_range = (tdas_pkg::LIM_W'(tok_end.target) < limit);
  assign conc_sat        = (conclusion > tdas_pkg::VERDICT_REJECT) ? tdas_pkg::VERDICT_REJECT
                                                                   : conclusion;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_states <= tdas_pkg::NUM_STATES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_states <= cfg_data;
    end
  end

  // Search token entering the first cell.
  always_comb begin
    launch        = '0;
    launch.valid  = accept && (operation == tdas_pkg::OP_PROCESS);
    launch.symbol = symbol;
    launch.state  = present_state;
  end

  // Load command seen by every cell.
  always_comb begin
    load            = '0;
    load.append     = accept && (operation == tdas_pkg::OP_APPEND) &&
                      (count != CW'(MAX_TRANSITIONS));
    load.add        = accept && (operation == tdas_pkg::OP_ADD_SYM) && (count != '0);
    load.from_state = from_state;
    load.to_state   = to_state;
    load.symbol     = symbol;
  end

  // Row of transition cells, in append order.
  assign tok[0] = launch;
  for (genvar i = 0; i < MAX_TRANSITIONS; i++) begin : g_cell
    tdas_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .count   (count),
      .load    (load),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end
  assign tok_end = tok[MAX_TRANSITIONS];

  // Conclusion store: written by configure items, read once the search has ended.
  assign conc_we = accept && (operation == tdas_pkg::OP_CONFIGURE) && idx_in_range;

  always_ff @(posedge clk) begin
    if (conc_we) begin
      conc_mem[state_index[CIW-1:0]] <= conc_sat;
    end
    conc_rd <= conc_mem[tok_end.target[CIW-1:0]];
  end

  // Entries never configured read as accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      conc_ok    <= '0;
      conc_rd_ok <= 1'b0;
    end else begin
      if (conc_we) begin
        conc_ok[state_index[CIW-1:0]] <= 1'b1;
      end
      conc_rd_ok <= conc_ok[tok_end.target[CIW-1:0]];
    end
  end

  // Control sequence, list fill count and present state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      present_state <= '0;
      res_verdict   <= tdas_pkg::VERDICT_CONTINUE;
      res_status    <= tdas_pkg::STATUS_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_verdict <= tdas_pkg::VERDICT_CONTINUE;
            if (operation == tdas_pkg::OP_PROCESS) begin
              state <= S_SCAN;
            end else begin
              state <= S_HOLD;
            end
            unique case (operation)
              tdas_pkg::OP_PROCESS: begin
                res_status <= tdas_pkg::STATUS_OK;
              end
              tdas_pkg::OP_APPEND: begin
                if (count == CW'(MAX_TRANSITIONS)) begin
                  res_status <= tdas_pkg::STATUS_FULL;
                end else begin
                  res_status <= tdas_pkg::STATUS_OK;
                  count      <= count + CW'(1);
                end
              end
              tdas_pkg::OP_ADD_SYM: begin
                if (count == '0) begin
                  res_status <= tdas_pkg::STATUS_NO_EXTEND;
                end else begin
                  res_status <= tdas_pkg::STATUS_OK;
                end
              end
              tdas_pkg::OP_CONFIGURE: begin
                if (!idx_in_range) begin
                  res_status <= tdas_pkg::STATUS_RANGE;
                end else begin
                  res_status <= tdas_pkg::STATUS_OK;
                end
              end
              tdas_pkg::OP_RESTART: begin
                res_status    <= tdas_pkg::STATUS_OK;
                present_state <= state_index;
              end
              default: begin
                res_status <= tdas_pkg::STATUS_OK;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (tok_end.valid) begin
            res_verdict <= tdas_pkg::VERDICT_REJECT;
            if (tok_end.hit) begin
              present_state <= tok_end.target;
              if (target_in_range) begin
                state <= S_CONC;
              end else begin
                state <= S_HOLD;
              end
            end else begin
              state <= S_HOLD;
            end
          end
        end
        S_CONC: begin
          res_verdict <= conc_rd_ok ? conc_rd : tdas_pkg::VERDICT_ACCEPT;
          state       <= S_HOLD;
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_HOLD && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_HOLD && out_free) begin
      verdict       <= res_verdict;
      current_state <= present_state;
      status        <= res_status;
    end
  end

endmodule

// ----- src/tdas_cell.sv -----
module tdas_cell #(
  parameter int CW  = 6,
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [CW-1:0]           count,
  input  tdas_pkg::load_t         load,
  input  tdas_pkg::token_t        tok_in,
  output tdas_pkg::token_t        tok_out
);

  logic [tdas_pkg::STATE_W-1:0]  from_state;
  logic [tdas_pkg::STATE_W-1:0]  to_state;
  logic [tdas_pkg::SET_BITS-1:0] sym_set;
  logic                          used;
  logic                          match;
  logic                          is_newest;
  logic                          is_free;
  tdas_pkg::token_t              tok_next;

  // This cell holds a live transition once the fill count has passed it.
  assign used      = (CW'(IDX) < count);
  assign is_free   = (CW'(IDX) == count);
  assign is_newest = (CW'(IDX + 1) == count);
  assign match     = used && (from_state == tok_in.state) && sym_set[tok_in.symbol];

  // Transition storage: filled on append, extended on add symbol.
  always_ff @(posedge clk) begin
    if (load.append && is_free) begin
      from_state <= load.from_state;
      to_state   <= load.to_state;
      sym_set    <= '0;
    end else if (load.add && is_newest) begin
      sym_set[load.symbol] <= 1'b1;
    end
  end

  // The first cell to match claims the token; later cells pass it on.
  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && !tok_in.hit && match) begin
      tok_next.hit    = 1'b1;
      tok_next.target = to_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule
